// File: design/assert_macros.svh
// Concurrent assertion helpers; expect clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: design/psrq_pkg.sv
`default_nettype none

package psrq_pkg;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PICK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_FIN
    } state_t;

    localparam int TASK_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 6;

endpackage

`default_nettype wire

// File: design/priority_sorted_run_queue.sv
// Run queue of task ids kept in descending priority order, FIFO among equal
// priorities, held in one slot memory that is walked one entry per cycle.
// Enqueue walks from the tail toward the head, shifting lower-priority
// entries back by one. Dequeue walks from the head, searching for the id and
// closing the gap as it goes. Pick, a full enqueue and an empty dequeue skip
// the walk. A response still stalled in the output register holds the block
// in its finishing state until it is taken. The memory port (one read, one
// write per cycle) paces the walks. Each request word yields one response
// word with the head, count and status; a finished response is held in an
// output register while the next request is taken. Priority uses the low
// PRIO_BITS bits of prio.
`default_nettype none

module priority_sorted_run_queue #(
    parameter int DEPTH     = 32,
    parameter int PRIO_BITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [1:0]                      action,
    input  wire logic [psrq_pkg::TASK_W-1:0]     task_id,
    input  wire logic [psrq_pkg::PRIO_W-1:0]     prio,

    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic                                 head_valid,
    output logic [psrq_pkg::TASK_W-1:0]          head_task,
    output logic [psrq_pkg::PRIO_W-1:0]          head_prio,
    output logic [psrq_pkg::COUNT_W-1:0]         count,
    output logic [1:0]                           status
);

`include "assert_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [psrq_pkg::TASK_W-1:0] tsk;
        logic [PRIO_BITS-1:0]        pri;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    logic    mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t  mem_wdata;

    psrq_pkg::state_t  state_reg, state_next;
    psrq_pkg::status_t stat_reg, stat_next;
    logic [CW-1:0]     occ_reg, occ_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [psrq_pkg::TASK_W-1:0] op_task_reg, op_task_next;
    logic [PRIO_BITS-1:0]        op_prio_reg, op_prio_next;
    logic [psrq_pkg::TASK_W-1:0] hd_task_reg, hd_task_next;
    logic [PRIO_BITS-1:0]        hd_prio_reg, hd_prio_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              out_hv_reg, out_hv_next;
    logic [psrq_pkg::TASK_W-1:0]  out_task_reg, out_task_next;
    logic [psrq_pkg::PRIO_W-1:0]  out_prio_reg, out_prio_next;
    logic [psrq_pkg::COUNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [1:0]        out_stat_reg, out_stat_next;

    logic              found_now;
    logic              last_slot;
    logic [CW-1:0]     occ_m1;

    assign occ_m1    = occ_reg - CW'(1);
    assign found_now = found_reg || (rdata_reg.tsk == op_task_reg);
    assign last_slot = (idx_reg == AW'(occ_m1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psrq_pkg::S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg     <= stat_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        op_task_reg  <= op_task_next;
        op_prio_reg  <= op_prio_next;
        hd_task_reg  <= hd_task_next;
        hd_prio_reg  <= hd_prio_next;
        out_hv_reg   <= out_hv_next;
        out_task_reg <= out_task_next;
        out_prio_reg <= out_prio_next;
        out_cnt_reg  <= out_cnt_next;
        out_stat_reg <= out_stat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        op_task_next   = op_task_reg;
        op_prio_next   = op_prio_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        out_hv_next    = out_hv_reg;
        out_task_next  = out_task_reg;
        out_prio_next  = out_prio_reg;
        out_cnt_next   = out_cnt_reg;
        out_stat_next  = out_stat_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rdata_reg;
        mem_raddr      = '0;

        unique case (state_reg)
            psrq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_task_next = task_id;
                    op_prio_next = PRIO_BITS'(prio);
                    unique case (action)
                        psrq_pkg::ACT_ENQ:
                        begin
                            if (occ_reg == CW'(DEPTH))
                            begin
                                stat_next  = psrq_pkg::STAT_FULL;
                                state_next = psrq_pkg::S_FIN;
                            end
                            else
                            begin
                                idx_next   = AW'(occ_reg);
                                mem_raddr  = AW'(occ_m1);
                                state_next = psrq_pkg::S_ENQ;
                            end
                        end
                        psrq_pkg::ACT_DEQ:
                        begin
                            if (occ_reg == '0)
                            begin
                                stat_next  = psrq_pkg::STAT_EMPTY;
                                state_next = psrq_pkg::S_FIN;
                            end
                            else
                            begin
                                idx_next   = '0;
                                found_next = 1'b0;
                                mem_raddr  = '0;
                                state_next = psrq_pkg::S_DEQ;
                            end
                        end
                        default:
                        begin
                            stat_next  = (occ_reg != '0) ? psrq_pkg::STAT_OK
                                                         : psrq_pkg::STAT_EMPTY;
                            state_next = psrq_pkg::S_FIN;
                        end
                    endcase
                end
            end

            // rdata_reg holds the slot just ahead of idx_reg
            psrq_pkg::S_ENQ:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if ((idx_reg == '0) || !(op_prio_reg > rdata_reg.pri))
                begin
                    mem_wdata.tsk = op_task_reg;
                    mem_wdata.pri = op_prio_reg;
                    occ_next      = occ_reg + CW'(1);
                    stat_next     = psrq_pkg::STAT_OK;
                    state_next    = psrq_pkg::S_FIN;
                end
                else
                begin
                    idx_next  = idx_reg - AW'(1);
                    mem_raddr = idx_reg - AW'(2);
                end
            end

            // rdata_reg holds the slot at idx_reg; after a hit, shift toward head
            psrq_pkg::S_DEQ:
            begin
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg - AW'(1);
                end
                if (last_slot)
                begin
                    if (found_now)
                    begin
                        occ_next  = occ_m1;
                        stat_next = psrq_pkg::STAT_OK;
                    end
                    else
                    begin
                        stat_next = psrq_pkg::STAT_NOT_FOUND;
                    end
                    state_next = psrq_pkg::S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    mem_raddr  = idx_reg + AW'(1);
                    found_next = found_now;
                end
            end

            psrq_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    out_hv_next    = (occ_reg != '0);
                    out_task_next  = (occ_reg != '0) ? hd_task_reg : '0;
                    out_prio_next  = (occ_reg != '0) ? psrq_pkg::PRIO_W'(hd_prio_reg) : '0;
                    out_cnt_next   = psrq_pkg::COUNT_W'(occ_reg);
                    out_stat_next  = stat_reg;
                    state_next     = psrq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = psrq_pkg::S_IDLE;
            end
        endcase
    end

    // head shadow tracks slot 0
    always_comb
    begin
        hd_task_next = hd_task_reg;
        hd_prio_next = hd_prio_reg;
        if (mem_we && (mem_waddr == '0))
        begin
            hd_task_next = mem_wdata.tsk;
            hd_prio_next = mem_wdata.pri;
        end
    end

    assign req_stall  = (state_reg != psrq_pkg::S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign head_valid = out_hv_reg;
    assign head_task  = out_task_reg;
    assign head_prio  = out_prio_reg;
    assign count      = out_cnt_reg;
    assign status     = out_stat_reg;

    `ASSERT_NEVER(a_occ_bound, occ_reg > CW'(DEPTH), "occupancy above depth")
    `ASSERT_CLK(a_we_busy, mem_we |-> (state_reg == psrq_pkg::S_ENQ || state_reg == psrq_pkg::S_DEQ), "slot write outside walk")
    `ASSERT_CLK(a_idle_occ, (state_reg == psrq_pkg::S_IDLE) |=> (occ_reg == $past(occ_reg)), "occupancy moved while idle")
    `ASSERT_CLK(a_enq_room, (state_reg == psrq_pkg::S_ENQ) |-> (occ_reg < CW'(DEPTH)), "enqueue walk on full queue")

endmodule

`default_nettype wire

// File: verif/tb_priority_sorted_run_queue.sv
`timescale 1ns / 1ps

localparam int QUEUE_DEPTH = 32;
localparam logic [1:0] ACT_SPARE = 2'd3;   // unused code, behaves like pick

typedef struct {
    logic                               head_valid;
    logic [psrq_pkg::TASK_W-1:0]        head_task;
    logic [psrq_pkg::PRIO_W-1:0]        head_prio;
    logic [psrq_pkg::COUNT_W-1:0]       count;
    psrq_pkg::status_t                  status;
} head_report_t;

class run_queue_scoreboard;
    logic [psrq_pkg::TASK_W-1:0]  q_tid  [QUEUE_DEPTH];
    logic [psrq_pkg::PRIO_W-1:0]  q_prio [QUEUE_DEPTH];
    int                 depth_used;
    int                 peak_depth;
    head_report_t       pending_heads[$];
    int                 errors;
    int                 words_in;
    int                 words_checked;
    int                 status_seen[4];

    function new();
        depth_used = 0;
        peak_depth = 0;
        errors = 0;
        words_in = 0;
        words_checked = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    task report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Sorted insert / first-match removal, then snapshot of the head.
    function void note_word(input logic [1:0] act, input logic [psrq_pkg::TASK_W-1:0] tid,
                            input logic [psrq_pkg::PRIO_W-1:0] pr);
        head_report_t      r;
        psrq_pkg::status_t st;
        int                pos;
        int                i;
        st = psrq_pkg::STAT_OK;
        if (act == psrq_pkg::ACT_ENQ) begin
            if (depth_used >= QUEUE_DEPTH) begin
                st = psrq_pkg::STAT_FULL;
            end
            else begin
                pos = depth_used;
                for (i = 0; i < depth_used; i++) begin
                    if (pr > q_prio[i]) begin
                        pos = i;
                        break;
                    end
                end
                for (i = depth_used; i > pos; i--) begin
                    q_tid[i]  = q_tid[i-1];
                    q_prio[i] = q_prio[i-1];
                end
                q_tid[pos]  = tid;
                q_prio[pos] = pr;
                depth_used++;
            end
        end
        else if (act == psrq_pkg::ACT_DEQ) begin
            if (depth_used == 0) begin
                st = psrq_pkg::STAT_EMPTY;
            end
            else begin
                pos = depth_used;
                for (i = 0; i < depth_used; i++) begin
                    if (q_tid[i] == tid) begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= depth_used) begin
                    st = psrq_pkg::STAT_NOT_FOUND;
                end
                else begin
                    for (i = pos; i + 1 < depth_used; i++) begin
                        q_tid[i]  = q_tid[i+1];
                        q_prio[i] = q_prio[i+1];
                    end
                    depth_used--;
                end
            end
        end
        else begin
            st = (depth_used > 0) ? psrq_pkg::STAT_OK : psrq_pkg::STAT_EMPTY;
        end

        r.head_valid = (depth_used > 0);
        r.head_task  = (depth_used > 0) ? q_tid[0]  : '0;
        r.head_prio  = (depth_used > 0) ? q_prio[0] : '0;
        r.count      = psrq_pkg::COUNT_W'(depth_used);
        r.status     = st;
        pending_heads.push_back(r);
        if (depth_used > peak_depth) peak_depth = depth_used;
        status_seen[st]++;
        words_in++;
    endfunction

    task check_word(input logic hv, input logic [psrq_pkg::TASK_W-1:0] ht,
                    input logic [psrq_pkg::PRIO_W-1:0] hp,
                    input logic [psrq_pkg::COUNT_W-1:0] cnt,
                    input logic [1:0] st);
        head_report_t exp;
        if (pending_heads.size() == 0) begin
            report_mismatch($sformatf("unexpected word head=%h prio=%h count=%0d status=%0d",
                                      ht, hp, cnt, st));
            return;
        end
        exp = pending_heads.pop_front();
        words_checked++;
        if (hv !== exp.head_valid)
            report_mismatch($sformatf("word %0d head_valid %b, want %b",
                                      words_checked, hv, exp.head_valid));
        if (ht !== exp.head_task)
            report_mismatch($sformatf("word %0d head_task %h, want %h",
                                      words_checked, ht, exp.head_task));
        if (hp !== exp.head_prio)
            report_mismatch($sformatf("word %0d head_prio %h, want %h",
                                      words_checked, hp, exp.head_prio));
        if (cnt !== exp.count)
            report_mismatch($sformatf("word %0d count %0d, want %0d",
                                      words_checked, cnt, exp.count));
        if (st !== exp.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      words_checked, st, exp.status));
    endtask
endclass

module tb_priority_sorted_run_queue;

    localparam int RANDOM_WORDS   = 800;
    localparam int BLOCK_WORDS    = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MODE_FILL      = 0;
    localparam int MODE_DRAIN     = 1;
    localparam int MODE_MIXED     = 2;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               req_valid = 1'b0;
    logic                               req_stall;
    logic [1:0]                         action = psrq_pkg::ACT_PICK;
    logic [psrq_pkg::TASK_W-1:0]        task_id = '0;
    logic [psrq_pkg::PRIO_W-1:0]        prio = '0;
    logic                               rsp_valid;
    logic                               rsp_stall = 1'b0;
    logic                               head_valid;
    logic [psrq_pkg::TASK_W-1:0]        head_task;
    logic [psrq_pkg::PRIO_W-1:0]        head_prio;
    logic [psrq_pkg::COUNT_W-1:0]       count;
    logic [1:0]                         status;

    int                   idle_pct = 28;
    int                   stuck_cycles = 0;
    run_queue_scoreboard  sb;

    priority_sorted_run_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .PRIO_BITS (psrq_pkg::PRIO_W)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .action     (action),
        .task_id    (task_id),
        .prio       (prio),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .head_valid (head_valid),
        .head_task  (head_task),
        .head_prio  (head_prio),
        .count      (count),
        .status     (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_word(head_valid, head_task, head_prio, count, status);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        rsp_stall <= ($urandom_range(99) < idle_pct);
    end

    initial
    begin
        while (stuck_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input logic [1:0] act, input logic [psrq_pkg::TASK_W-1:0] tid,
                             input logic [psrq_pkg::PRIO_W-1:0] pr);
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        task_id   <= tid;
        prio      <= pr;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_word(act, tid, pr);
    endtask

    task automatic send_random(input int mode);
        int                           roll;
        int                           enq_lim;
        int                           deq_lim;
        logic [1:0]                   act;
        logic [psrq_pkg::TASK_W-1:0]  tid;
        logic [psrq_pkg::PRIO_W-1:0]  pr;
        enq_lim = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 15 : 40;
        deq_lim = enq_lim + ((mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 75 : 45);
        roll = $urandom_range(99);
        if (roll < enq_lim)
            act = psrq_pkg::ACT_ENQ;
        else if (roll < deq_lim)
            act = psrq_pkg::ACT_DEQ;
        else
            act = ($urandom_range(2) == 0) ? ACT_SPARE : psrq_pkg::ACT_PICK;

        // narrow ids make duplicates likely
        if ($urandom_range(1) == 0)
            tid = psrq_pkg::TASK_W'($urandom_range(15));
        else
            tid = psrq_pkg::TASK_W'($urandom_range(65535));
        if (act == psrq_pkg::ACT_DEQ && sb.depth_used > 0 && $urandom_range(9) < 8)
            tid = sb.q_tid[$urandom_range(sb.depth_used - 1)];

        // coarse levels give many equal priorities
        if ($urandom_range(1) == 0)
            pr = psrq_pkg::PRIO_W'($urandom_range(3) * 85);
        else
            pr = psrq_pkg::PRIO_W'($urandom_range(255));
        send_word(act, tid, pr);
    endtask

    initial
    begin
        int           mode;
        head_report_t missing;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-queue behavior, boundary ids and priorities, FIFO ties, duplicates
        send_word(psrq_pkg::ACT_PICK, 16'h0000, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'hFFFF, 8'hFF);
        send_word(ACT_SPARE,          16'h5A5A, 8'hA5);
        send_word(psrq_pkg::ACT_ENQ,  16'h0000, 8'h00);
        send_word(psrq_pkg::ACT_ENQ,  16'hFFFF, 8'hFF);
        send_word(psrq_pkg::ACT_ENQ,  16'h1234, 8'hFF);
        send_word(psrq_pkg::ACT_ENQ,  16'h00AA, 8'h80);
        send_word(psrq_pkg::ACT_ENQ,  16'h0000, 8'h80);
        send_word(psrq_pkg::ACT_ENQ,  16'hAAAA, 8'h7F);
        send_word(psrq_pkg::ACT_PICK, 16'h0000, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'hBEEF, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'h0000, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'h0000, 8'h00);
        send_word(ACT_SPARE,          16'h0000, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'hFFFF, 8'h00);
        send_word(psrq_pkg::ACT_ENQ,  16'h5555, 8'hFF);
        send_word(psrq_pkg::ACT_DEQ,  16'h1234, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'h00AA, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'hAAAA, 8'h00);
        send_word(psrq_pkg::ACT_DEQ,  16'h5555, 8'h00);
        send_word(psrq_pkg::ACT_PICK, 16'hFFFF, 8'hFF);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            case ((n / BLOCK_WORDS) % 5)
                0, 1:    mode = MODE_FILL;
                2:       mode = MODE_MIXED;
                default: mode = MODE_DRAIN;
            endcase
            idle_pct = (n >= 320 && n < 440) ? 0 : 28;
            send_random(mode);
        end
        req_valid <= 1'b0;
        idle_pct = 28;

        while (sb.pending_heads.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (sb.pending_heads.size() != 0) begin
            missing = sb.pending_heads.pop_front();
            sb.report_mismatch($sformatf("missing word, want count %0d", missing.count));
        end
        $display("Covered %0d requests, %0d responses checked, peak depth %0d of %0d",
                 sb.words_in, sb.words_checked, sb.peak_depth, QUEUE_DEPTH);
        $display("Status mix: ok %0d, full %0d, not found %0d, empty %0d; mismatches %0d",
                 sb.status_seen[psrq_pkg::STAT_OK], sb.status_seen[psrq_pkg::STAT_FULL],
                 sb.status_seen[psrq_pkg::STAT_NOT_FOUND],
                 sb.status_seen[psrq_pkg::STAT_EMPTY], sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
